>>> rtl/core/dbr_pkg.sv
// ----------------------------------------------------------------------------
// dbr_pkg
// Types, codes and the symbol table shared by the randomart block.
// ----------------------------------------------------------------------------
package dbr_pkg;

  // item modes
  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_WALK  = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam int unsigned MOVES_PER_BYTE = 4;

  localparam logic [3:0] COUNT_MAX  = 4'd14;
  localparam logic [4:0] CODE_START = 5'd15;
  localparam logic [4:0] CODE_END   = 5'd16;
  localparam logic [6:0] CHAR_SPACE = 7'd32;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
    logic [7:0] cell_index;
  } dbr_in_t;

  typedef struct packed {
    logic [7:0] position;
    logic [4:0] symbol_code;
    logic [6:0] symbol_char;
  } dbr_out_t;

  // ascii character for a cell code, " .o+=*BOX@%&#/^SE"
  function automatic logic [6:0] glyph(input logic [4:0] code);
    logic [6:0] ch;
    case (code)
      5'd0:    ch = 7'd32;  // ' '
      5'd1:    ch = 7'd46;  // '.'
      5'd2:    ch = 7'd111; // 'o'
      5'd3:    ch = 7'd43;  // '+'
      5'd4:    ch = 7'd61;  // '='
      5'd5:    ch = 7'd42;  // '*'
      5'd6:    ch = 7'd66;  // 'B'
      5'd7:    ch = 7'd79;  // 'O'
      5'd8:    ch = 7'd88;  // 'X'
      5'd9:    ch = 7'd64;  // '@'
      5'd10:   ch = 7'd37;  // '%'
      5'd11:   ch = 7'd38;  // '&'
      5'd12:   ch = 7'd35;  // '#'
      5'd13:   ch = 7'd47;  // '/'
      5'd14:   ch = 7'd94;  // '^'
      5'd15:   ch = 7'd83;  // 'S'
      5'd16:   ch = 7'd69;  // 'E'
      default: ch = CHAR_SPACE;
    endcase
    return ch;
  endfunction

endpackage

>>> rtl/core/dbr_board_mem.sv
// ----------------------------------------------------------------------------
// dbr_board_mem
// Visit count store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dbr_board_mem #(
  parameter int unsigned DEPTH  = 153,
  parameter int unsigned ADDR_W = 8,
  parameter int unsigned DATA_W = 4
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/drunken_bishop_randomart.sv
// ----------------------------------------------------------------------------
// drunken_bishop_randomart
// Drunken-bishop fingerprint walk over a board of visit counts held in RAM.
// ----------------------------------------------------------------------------
// The board lives in a single-port-write, single-port-read RAM with registered
// read data. A walk item makes four moves, one per cycle; each move reads the
// target cell and the following cycle writes the saturated count back, so a
// walk item goes through acceptance, four moves, the final write-back and the
// output load; a read item through acceptance, the RAM read and the output
// load. A clear item, and reset itself, sweep the RAM one cell a cycle over
// all BOARD_WIDTH * BOARD_HEIGHT cells (153 by default), during which no item
// is taken; the clear item's result follows the sweep. Only one item is in
// flight at a time; its result sits in an output register until taken.
module drunken_bishop_randomart
  import dbr_pkg::*;
#(
  parameter int unsigned BOARD_WIDTH  = 17,
  parameter int unsigned BOARD_HEIGHT = 9
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dbr_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output dbr_out_t out_data_o
);

  localparam int unsigned CELL_COUNT = BOARD_WIDTH * BOARD_HEIGHT;
  localparam int unsigned POS_W      = $clog2(CELL_COUNT);
  localparam int unsigned CMP_W      = (POS_W > 8) ? POS_W : 8;
  localparam int unsigned X_W        = $clog2(BOARD_WIDTH);
  localparam int unsigned Y_W        = $clog2(BOARD_HEIGHT);
  localparam int unsigned START_X    = BOARD_WIDTH / 2;
  localparam int unsigned START_Y    = BOARD_HEIGHT / 2;
  localparam int unsigned START_CELL = START_Y * BOARD_WIDTH + START_X;

  localparam logic [POS_W-1:0] START_POS = POS_W'(START_CELL);
  localparam logic [POS_W-1:0] LAST_POS  = POS_W'(CELL_COUNT - 1);
  localparam logic [POS_W-1:0] STEP_ONE  = POS_W'(1);
  localparam logic [POS_W-1:0] STEP_BACK = ~POS_W'(0);
  localparam logic [POS_W-1:0] ROW_FWD   = POS_W'(BOARD_WIDTH);
  localparam logic [POS_W-1:0] ROW_BACK  = ~ROW_FWD + POS_W'(1);
  localparam logic [X_W-1:0]   X_START   = X_W'(START_X);
  localparam logic [X_W-1:0]   X_LAST    = X_W'(BOARD_WIDTH - 1);
  localparam logic [Y_W-1:0]   Y_START   = Y_W'(START_Y);
  localparam logic [Y_W-1:0]   Y_LAST    = Y_W'(BOARD_HEIGHT - 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_WALK  = 3'd2;
  localparam logic [2:0] ST_FLUSH = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [X_W-1:0]   x_q, x_d;
  logic [Y_W-1:0]   y_q, y_d;
  logic [7:0]       byte_q, byte_d;
  logic [1:0]       step_q, step_d;
  logic             wr_pend_q, wr_pend_d;
  logic [POS_W-1:0] wr_addr_q, wr_addr_d;
  logic [POS_W-1:0] clr_addr_q, clr_addr_d;
  logic             clr_reply_q, clr_reply_d;
  logic             use_mem_q, use_mem_d;
  logic [4:0]       code_q, code_d;
  logic             out_valid_q, out_valid_d;
  dbr_out_t         out_data_q, out_data_d;

  logic             mem_we, mem_re;
  logic [POS_W-1:0] mem_waddr, mem_raddr;
  logic [3:0]       mem_wdata, mem_rdata;

  logic             x_inc, x_dec, y_inc, y_dec, moved;
  logic [POS_W-1:0] step_x, step_y, new_pos;
  logic [CMP_W-1:0] cell_ext, pos_ext;
  logic             cell_in_range, accept, out_free;

  dbr_board_mem #(
    .DEPTH  (CELL_COUNT),
    .ADDR_W (POS_W),
    .DATA_W (4)
  ) u_board_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // one diagonal move from the current cell, clamped at the edges
  assign x_inc   = byte_q[0] && (x_q != X_LAST);
  assign x_dec   = !byte_q[0] && (x_q != '0);
  assign y_inc   = byte_q[1] && (y_q != Y_LAST);
  assign y_dec   = !byte_q[1] && (y_q != '0);
  assign moved   = x_inc || x_dec || y_inc || y_dec;
  assign step_x  = x_inc ? STEP_ONE : (x_dec ? STEP_BACK : '0);
  assign step_y  = y_inc ? ROW_FWD : (y_dec ? ROW_BACK : '0);
  assign new_pos = pos_q + step_x + step_y;

  assign cell_ext      = CMP_W'(in_data_i.cell_index);
  assign pos_ext       = CMP_W'(pos_q);
  assign cell_in_range = cell_ext < CMP_W'(CELL_COUNT);

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // write port: clear sweep, or the count write-back the cycle after a move.
  // a move never reads the cell written in the same cycle: that cell is the
  // one the bishop stands on, and a move that reads always leaves it
  always_comb begin
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_q;
      mem_wdata = '0;
    end else begin
      mem_we    = wr_pend_q;
      mem_waddr = wr_addr_q;
      mem_wdata = (mem_rdata == COUNT_MAX) ? mem_rdata : mem_rdata + 4'd1;
    end
  end

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = new_pos;
    if (state_q == ST_WALK) begin
      mem_re = moved;
    end else if (accept && (in_data_i.mode == MODE_READ) && cell_in_range) begin
      mem_re    = 1'b1;
      mem_raddr = cell_ext[POS_W-1:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    x_d         = x_q;
    y_d         = y_q;
    byte_d      = byte_q;
    step_d      = step_q;
    wr_pend_d   = 1'b0;
    wr_addr_d   = wr_addr_q;
    clr_addr_d  = clr_addr_q;
    clr_reply_d = clr_reply_q;
    use_mem_d   = use_mem_q;
    code_d      = code_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;

    case (state_q)
      ST_CLEAR: begin
        clr_addr_d = clr_addr_q + POS_W'(1);
        if (clr_addr_q == LAST_POS) begin
          clr_reply_d = 1'b0;
          state_d     = clr_reply_q ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          code_d    = '0;
          use_mem_d = 1'b0;
          case (in_data_i.mode)
            MODE_CLEAR: begin
              pos_d       = START_POS;
              x_d         = X_START;
              y_d         = Y_START;
              clr_addr_d  = '0;
              clr_reply_d = 1'b1;
              state_d     = ST_CLEAR;
            end
            MODE_WALK: begin
              byte_d  = in_data_i.data_byte;
              step_d  = '0;
              state_d = ST_WALK;
            end
            MODE_READ: begin
              if (cell_in_range) begin
                if (cell_ext == CMP_W'(START_CELL)) begin
                  code_d = CODE_START;
                end else if (cell_ext == pos_ext) begin
                  code_d = CODE_END;
                end else begin
                  use_mem_d = 1'b1;
                end
              end
              state_d = ST_READ;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_WALK: begin
        if (moved) begin
          pos_d     = new_pos;
          x_d       = x_inc ? x_q + X_W'(1) : (x_dec ? x_q - X_W'(1) : x_q);
          y_d       = y_inc ? y_q + Y_W'(1) : (y_dec ? y_q - Y_W'(1) : y_q);
          wr_pend_d = 1'b1;
          wr_addr_d = new_pos;
        end
        byte_d = {2'b00, byte_q[7:2]};
        step_d = step_q + 2'd1;
        if (step_q == 2'(MOVES_PER_BYTE - 1)) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_d = ST_DONE;
      end
      ST_READ: begin
        if (use_mem_q) begin
          code_d = {1'b0, mem_rdata};
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d            = 1'b1;
          out_data_d.position    = pos_ext[7:0];
          out_data_d.symbol_code = code_q;
          out_data_d.symbol_char = glyph(code_q);
          state_d                = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      pos_q       <= START_POS;
      x_q         <= X_START;
      y_q         <= Y_START;
      step_q      <= '0;
      wr_pend_q   <= 1'b0;
      clr_addr_q  <= '0;
      clr_reply_q <= 1'b0;
      use_mem_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      x_q         <= x_d;
      y_q         <= y_d;
      step_q      <= step_d;
      wr_pend_q   <= wr_pend_d;
      clr_addr_q  <= clr_addr_d;
      clr_reply_q <= clr_reply_d;
      use_mem_q   <= use_mem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q     <= byte_d;
    wr_addr_q  <= wr_addr_d;
    code_q     <= code_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> tb/drunken_bishop_randomart_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drunken_bishop_randomart_check
// Watches both channels of the randomart block, keeps its own board of visit
// counts and bishop position, and compares every result with the prediction.
// ----------------------------------------------------------------------------
module drunken_bishop_randomart_check
  import dbr_pkg::*;
#(
  parameter int unsigned BOARD_WIDTH  = 17,
  parameter int unsigned BOARD_HEIGHT = 9
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_ready_i,
  input  dbr_in_t  in_data_i,
  input  logic     out_valid_i,
  input  logic     out_ready_i,
  input  dbr_out_t out_data_i,
  output int       pending_o,
  output int       fail_count_o,
  output int       checked_o,
  output int       saturated_reads_o
);

  localparam int unsigned CELLS     = BOARD_WIDTH * BOARD_HEIGHT;
  localparam int unsigned HOME_CELL = (BOARD_HEIGHT / 2) * BOARD_WIDTH + BOARD_WIDTH / 2;

  // display characters, code 0 in the top byte
  localparam logic [8*17-1:0] ART_CHARS = " .o+=*BOX@%&#/^SE";

  logic [3:0]  visits [CELLS];
  int unsigned bishop;
  dbr_out_t    awaited_q [$];
  int          fails;
  int          checked;
  int          saturated;

  assign fail_count_o      = fails;
  assign checked_o         = checked;
  assign saturated_reads_o = saturated;

  function automatic void clear_board();
    for (int c = 0; c < CELLS; c++) begin
      visits[c] = '0;
    end
    bishop = HOME_CELL;
  endfunction

  // advances the board by one item and returns the result it should give
  function automatic dbr_out_t bishop_step(input dbr_in_t item);
    dbr_out_t    res;
    logic [1:0]  dir;
    int unsigned col;
    int unsigned row;
    int unsigned next;
    logic [4:0]  code;

    code = '0;
    res.symbol_char = CHAR_SPACE;
    case (item.mode)
      MODE_CLEAR: begin
        clear_board();
      end
      MODE_WALK: begin
        for (int k = 0; k < MOVES_PER_BYTE; k++) begin
          dir = item.data_byte[2*k +: 2];
          col = bishop % BOARD_WIDTH;
          row = bishop / BOARD_WIDTH;
          if (dir[0]) begin
            if (col < BOARD_WIDTH - 1) col++;
          end else if (col > 0) begin
            col--;
          end
          if (dir[1]) begin
            if (row < BOARD_HEIGHT - 1) row++;
          end else if (row > 0) begin
            row--;
          end
          next = row * BOARD_WIDTH + col;
          // only a real move leaves a mark
          if (next != bishop && next < CELLS) begin
            bishop = next;
            if (visits[next] < COUNT_MAX) visits[next] = visits[next] + 4'd1;
          end
        end
      end
      MODE_READ: begin
        if (item.cell_index < CELLS) begin
          if (item.cell_index == HOME_CELL) code = CODE_START;
          else if (item.cell_index == bishop) code = CODE_END;
          else code = {1'b0, visits[item.cell_index]};
          res.symbol_char = ART_CHARS[8*(16-code) +: 7];
        end
      end
      default: begin
      end
    endcase
    res.symbol_code = code;
    res.position    = bishop[7:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    dbr_out_t want;
    dbr_out_t got;
    if (!rst_ni) begin
      clear_board();
      awaited_q.delete();
      fails     = 0;
      checked   = 0;
      saturated = 0;
      pending_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        want = bishop_step(in_data_i);
        if (in_data_i.mode == MODE_READ && want.symbol_code == {1'b0, COUNT_MAX}) begin
          saturated++;
        end
        awaited_q.push_back(want);
      end
      if (out_valid_i && out_ready_i) begin
        got = out_data_i;
        if (awaited_q.size() == 0) begin
          $error("result with no item waiting: position %0d code %0d char %0d",
                 got.position, got.symbol_code, got.symbol_char);
          fails++;
        end else begin
          want = awaited_q.pop_front();
          checked++;
          if (got.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, got.position);
            fails++;
          end
          if (got.symbol_code !== want.symbol_code) begin
            $error("symbol_code: expected %0d, got %0d", want.symbol_code, got.symbol_code);
            fails++;
          end
          if (got.symbol_char !== want.symbol_char) begin
            $error("symbol_char: expected %0d, got %0d", want.symbol_char, got.symbol_char);
            fails++;
          end
        end
      end
      pending_o <= awaited_q.size();
    end
  end

endmodule

>>> tb/drunken_bishop_randomart_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drunken_bishop_randomart_test
// Drives directed and random clear, walk, read, ignored items to the randomart
// block under bursty input and a stalling output; the checker judges results.
// ----------------------------------------------------------------------------
module drunken_bishop_randomart_test
  import dbr_pkg::*;
();

  localparam int unsigned BOARD_W        = 17;
  localparam int unsigned BOARD_H        = 9;
  localparam int unsigned CELLS          = BOARD_W * BOARD_H;
  localparam int unsigned HOME_CELL      = (BOARD_H / 2) * BOARD_W + BOARD_W / 2;
  localparam logic [1:0]  MODE_IGNORED   = 2'd3;
  localparam int          RANDOM_ITEMS   = 500;
  localparam int          WATCHDOG_LIMIT = 2000;

  // walk bytes that bounce between two cells and drive counts to saturation
  localparam logic [7:0] BOUNCE_A = 8'hCC;
  localparam logic [7:0] BOUNCE_B = 8'h33;
  localparam logic [7:0] BOUNCE_C = 8'h66;
  localparam logic [7:0] BOUNCE_D = 8'h99;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  dbr_in_t  in_data = '0;
  logic     out_ready = 1'b0;
  logic     in_ready_o;
  logic     out_valid_o;
  dbr_out_t out_data_o;

  int       pending;
  int       fail_count;
  int       checked;
  int       saturated_reads;

  int       burst_left = 0;
  int       quiet = 0;
  int       ready_cycle = 0;
  int       ready_style = 0;
  logic [7:0] last_position = 8'(HOME_CELL);
  int       walks = 0;
  int       reads = 0;
  int       clears = 0;
  int       ignored = 0;

  always #4 clk_i = ~clk_i;

  drunken_bishop_randomart #(
    .BOARD_WIDTH (BOARD_W),
    .BOARD_HEIGHT(BOARD_H)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o (out_data_o)
  );

  drunken_bishop_randomart_check #(
    .BOARD_WIDTH (BOARD_W),
    .BOARD_HEIGHT(BOARD_H)
  ) checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready_o),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready),
    .out_data_i       (out_data_o),
    .pending_o        (pending),
    .fail_count_o     (fail_count),
    .checked_o        (checked),
    .saturated_reads_o(saturated_reads)
  );

  // receiver: switches between always ready, coin flips and a sparse pattern
  always @(posedge clk_i) begin
    if (ready_cycle % 128 == 0) ready_style <= $urandom_range(0, 2);
    ready_cycle <= ready_cycle + 1;
    case (ready_style)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= (ready_cycle % 5 == 0);
    endcase
  end

  // last position the block reported, used to aim reads at the bishop
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready) last_position <= out_data_o.position;
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic push_item(input logic [1:0] mode, input logic [7:0] data,
                           input logic [7:0] target);
    dbr_in_t item;
    item.mode       = mode;
    item.data_byte  = data;
    item.cell_index = target;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    case (mode)
      MODE_CLEAR: clears++;
      MODE_WALK:  walks++;
      MODE_READ:  reads++;
      default:    ignored++;
    endcase
    // bursts of back-to-back items separated by random gaps
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(0, 24);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    int pick;
    int sel;
    logic [7:0] data;
    logic [7:0] target;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // start cell is also the end cell after reset; edges and outside reads
    push_item(MODE_READ, 8'h00, 8'(HOME_CELL));
    push_item(MODE_READ, 8'hFF, 8'd0);
    push_item(MODE_READ, 8'h00, 8'(CELLS - 1));
    push_item(MODE_READ, 8'h00, 8'hFF);
    // zero bytes drive the bishop into the top left corner, then clamp
    push_item(MODE_WALK, 8'h00, 8'h00);
    push_item(MODE_WALK, 8'h00, 8'h00);
    push_item(MODE_WALK, 8'h00, 8'h00);
    push_item(MODE_READ, 8'h00, 8'd0);
    // bounce until both cells saturate
    repeat (8) push_item(MODE_WALK, BOUNCE_A, 8'h00);
    push_item(MODE_READ, 8'h00, 8'd0);
    push_item(MODE_READ, 8'h00, 8'(BOARD_W + 1));
    push_item(MODE_IGNORED, 8'hFF, 8'hFF);
    repeat (3) push_item(MODE_WALK, 8'hFF, 8'hFF);
    push_item(MODE_READ, 8'h00, 8'(CELLS - 1));
    push_item(MODE_WALK, 8'h55, 8'h00);
    push_item(MODE_CLEAR, 8'hFF, 8'hFF);
    push_item(MODE_READ, 8'h00, 8'(HOME_CELL));
    push_item(MODE_READ, 8'h00, 8'(CELLS - 1));
    drain();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 120 == 119) drain();
      pick = $urandom_range(0, 99);
      data = 8'($urandom);
      target = 8'($urandom);
      if (pick < 3) begin
        push_item(MODE_CLEAR, data, target);
      end else if (pick < 6) begin
        push_item(MODE_IGNORED, data, target);
      end else if (pick < 56) begin
        if ($urandom_range(0, 3) == 0) begin
          case ($urandom_range(0, 3))
            0:       data = BOUNCE_A;
            1:       data = BOUNCE_B;
            2:       data = BOUNCE_C;
            default: data = BOUNCE_D;
          endcase
        end
        push_item(MODE_WALK, data, target);
      end else begin
        sel = $urandom_range(0, 9);
        if (sel < 6) target = 8'($urandom_range(0, CELLS - 1));
        else if (sel == 6) target = 8'(HOME_CELL);
        else if (sel == 7) target = last_position;
        else if (sel == 8) target = 8'($urandom_range(CELLS, 255));
        push_item(MODE_READ, data, target);
      end
    end

    drain();
    repeat (20) @(posedge clk_i);

    $display("covered %0d walks, %0d reads, %0d clears and %0d ignored items",
             walks, reads, clears, ignored);
    $display("%0d results compared, %0d reads of saturated cells", checked, saturated_reads);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> drunken_bishop_randomart.f
rtl/core/dbr_pkg.sv
rtl/core/dbr_board_mem.sv
rtl/core/drunken_bishop_randomart.sv
tb/drunken_bishop_randomart_check.sv
tb/drunken_bishop_randomart_test.sv
